// ===== hw/rtl/grr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_pkg: shared types and constants of the Gauss-Jordan row reducer
// Item layouts, configuration register indexes and default sizes.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_MAX_COLS  = 8;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic CFG_VAR_COUNT = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] elem_value;
        logic               last_elem;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] out_value;
        logic               out_last;
    } t_out_item;

endpackage

// ===== hw/rtl/gauss_jordan_row_reducer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_row_reducer: fixed-point reduction to reduced row echelon form
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   in      | i_in_valid / o_in_stall   | i_in_item   (row, col, value, last)
//   out     | o_out_valid / i_out_stall | o_out_item  (row, col, value, last)
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A non-last item is stored as it is accepted. The last item starts the reduction:
// each division runs in the shared restoring divider, each multiply-subtract
// goes through the single multiplier, and every emitted item waits out any
// output stall. All reads and
// writes go through one coefficient memory with a registered read port.
// Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
module gauss_jordan_row_reducer #(
    parameter int MAX_ROWS  = grr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = grr_pkg::DEF_MAX_COLS,
    parameter int FRAC_BITS = grr_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  grr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output grr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data
);
    import grr_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RW1   = $clog2(MAX_ROWS + 1);
    localparam int CW1   = $clog2(MAX_COLS + 1);
    localparam int NW    = 32 + FRAC_BITS;
    localparam int KW    = $clog2(NW + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_COL   = 5'd1;
    localparam logic [4:0] S_PRD   = 5'd2;
    localparam logic [4:0] S_PCHK  = 5'd3;
    localparam logic [4:0] S_DRD   = 5'd4;
    localparam logic [4:0] S_DLD   = 5'd5;
    localparam logic [4:0] S_DRUN  = 5'd6;
    localparam logic [4:0] S_DWR   = 5'd7;
    localparam logic [4:0] S_ERD   = 5'd8;
    localparam logic [4:0] S_ECHK  = 5'd9;
    localparam logic [4:0] S_MRA   = 5'd10;
    localparam logic [4:0] S_MRB   = 5'd11;
    localparam logic [4:0] S_MMUL  = 5'd12;
    localparam logic [4:0] S_MSCL  = 5'd13;
    localparam logic [4:0] S_MWR   = 5'd14;
    localparam logic [4:0] S_ORD   = 5'd15;
    localparam logic [4:0] S_OLD   = 5'd16;
    localparam logic [4:0] S_OWAIT = 5'd17;

    logic [31:0] mem [DEPTH];

    logic [4:0]          r_state;
    logic [2:0]          r_var_count;
    logic [3:0]          r_row_count;
    logic [RW1-1:0]      r_rows;
    logic [CW1-1:0]      r_width;
    logic [CW1-1:0]      r_x;
    logic [CW1-1:0]      r_c;
    logic [RW1-1:0]      r_y;
    logic [RW1-1:0]      r_r;
    logic [MAX_ROWS-1:0] r_used;
    logic signed [31:0]  r_rdata;
    logic signed [31:0]  r_piv;
    logic signed [31:0]  r_f;
    logic signed [31:0]  r_b;
    logic signed [31:0]  r_a;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_scaled;
    logic [NW-1:0]       r_num;
    logic [NW-1:0]       r_quo;
    logic [32:0]         r_rem;
    logic [31:0]         r_den;
    logic [KW-1:0]       r_cnt;
    logic                r_neg;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [32:0]        n_rem;
    logic signed [31:0] div_res;
    logic signed [63:0] diff;
    logic signed [31:0] ms_res;
    logic [31:0]        a_mag;
    logic [31:0]        p_mag;
    logic [31:0]        out_row_w;
    logic [31:0]        out_col_w;
    logic               in_fire;
    logic               in_store;

    function automatic logic [AW-1:0] addr_of(input logic [RW1-1:0] row,
                                              input logic [CW1-1:0] col);
        return AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign in_store    = (int'(i_in_item.row_index) < MAX_ROWS)
                      && (int'(i_in_item.col_index) < MAX_COLS);

    always_comb begin
        rd_addr = addr_of(r_y, r_x);
        case (r_state)
            S_DRD:   rd_addr = addr_of(r_y, r_c);
            S_ERD:   rd_addr = addr_of(r_r, r_x);
            S_MRA:   rd_addr = addr_of(r_y, r_c);
            S_MRB:   rd_addr = addr_of(r_r, r_c);
            S_ORD:   rd_addr = addr_of(r_r, r_c);
            default: rd_addr = addr_of(r_y, r_x);
        endcase
    end

    always_comb begin
        n_rem = {r_rem[31:0], r_num[NW-1]};
        if (n_rem >= {1'b0, r_den}) begin
            n_rem = n_rem - {1'b0, r_den};
        end
    end

    always_comb begin
        if (!r_neg) begin
            div_res = (r_quo > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(r_quo[31:0]);
        end else begin
            div_res = (r_quo > NW'(64'h8000_0000)) ? 32'sh8000_0000
                                                   : $signed(~r_quo[31:0] + 32'd1);
        end
        diff = 64'(r_a) - r_scaled;
        if (diff > 64'sh7FFF_FFFF) begin
            ms_res = 32'sh7FFF_FFFF;
        end else if (diff < -64'sh8000_0000) begin
            ms_res = 32'sh8000_0000;
        end else begin
            ms_res = diff[31:0];
        end
        a_mag     = r_rdata[31] ? (~r_rdata + 32'd1) : r_rdata;
        p_mag     = r_piv[31] ? (~r_piv + 32'd1) : r_piv;
        out_row_w = 32'(r_r);
        out_col_w = 32'(r_c);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_of(r_y, r_c);
        wr_data = div_res;
        case (r_state)
            S_IDLE: begin
                wr_en   = in_fire && in_store;
                wr_addr = AW'(i_in_item.row_index) * AW'(MAX_COLS) + AW'(i_in_item.col_index);
                wr_data = i_in_item.elem_value;
            end
            S_DWR: begin
                wr_en = 1'b1;
            end
            S_MWR: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(r_r, r_c);
                wr_data = ms_res;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_var_count <= 3'd7;
            r_row_count <= 4'd8;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VAR_COUNT: r_var_count <= i_cfg_data[2:0];
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire && i_in_item.last_elem) begin
                        r_rows  <= (int'(r_row_count) > MAX_ROWS) ? RW1'(MAX_ROWS)
                                                                   : RW1'(r_row_count);
                        r_width <= (int'(r_var_count) + 1 > MAX_COLS) ? CW1'(MAX_COLS)
                                                                       : CW1'(r_var_count + 4'd1);
                        r_used  <= '0;
                        r_x     <= '0;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    if ({1'b0, r_x} + 1'b1 >= {1'b0, r_width}) begin
                        r_r     <= '0;
                        r_c     <= '0;
                        r_state <= (r_rows == '0) ? S_IDLE : S_ORD;
                    end else begin
                        r_y     <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    if (r_y >= r_rows) begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_COL;
                    end else if (r_used[r_y[RW-1:0]]) begin
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    if (r_rdata == '0) begin
                        r_y     <= r_y + 1'b1;
                        r_state <= S_PRD;
                    end else begin
                        r_piv   <= r_rdata;
                        r_c     <= '0;
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    if (r_c >= r_width) begin
                        r_used[r_y[RW-1:0]] <= 1'b1;
                        r_r                 <= '0;
                        r_state             <= S_ERD;
                    end else begin
                        r_state <= S_DLD;
                    end
                end
                S_DLD: begin
                    r_neg   <= r_rdata[31] ^ r_piv[31];
                    r_num   <= {a_mag, FRAC_BITS'(0)};
                    r_den   <= p_mag;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= KW'(NW);
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[NW-2:0],
                              ({r_rem[31:0], r_num[NW-1]} >= {1'b0, r_den})};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == KW'(1)) begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_c     <= r_c + 1'b1;
                    r_state <= S_DRD;
                end
                S_ERD: begin
                    if (r_r >= r_rows) begin
                        r_y     <= r_y + 1'b1;
                        r_state <= S_PRD;
                    end else if (r_r == r_y) begin
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_state <= S_ECHK;
                    end
                end
                S_ECHK: begin
                    if (r_rdata == '0) begin
                        r_r     <= r_r + 1'b1;
                        r_state <= S_ERD;
                    end else begin
                        r_f     <= r_rdata;
                        r_c     <= '0;
                        r_state <= S_MRA;
                    end
                end
                S_MRA: begin
                    if (r_c >= r_width) begin
                        r_r     <= r_r + 1'b1;
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_MRB;
                    end
                end
                S_MRB: begin
                    r_b     <= r_rdata;
                    r_state <= S_MMUL;
                end
                S_MMUL: begin
                    r_a     <= r_rdata;
                    r_prod  <= 64'(r_b) * 64'(r_f);
                    r_state <= S_MSCL;
                end
                S_MSCL: begin
                    r_scaled <= (r_prod + (r_prod[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1)
                                                      : 64'sd0)) >>> FRAC_BITS;
                    r_state  <= S_MWR;
                end
                S_MWR: begin
                    r_c     <= r_c + 1'b1;
                    r_state <= S_MRA;
                end
                S_ORD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_out.out_row   <= out_row_w[2:0];
                    r_out.out_col   <= out_col_w[2:0];
                    r_out.out_value <= r_rdata;
                    r_out.out_last  <= ({1'b0, r_r} + 1'b1 == {1'b0, r_rows})
                                    && ({1'b0, r_c} + 1'b1 == {1'b0, r_width});
                    r_out_valid     <= 1'b1;
                    r_state         <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if ({1'b0, r_c} + 1'b1 < {1'b0, r_width}) begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_ORD;
                        end else if ({1'b0, r_r} + 1'b1 < {1'b0, r_rows}) begin
                            r_r     <= r_r + 1'b1;
                            r_c     <= '0;
                            r_state <= S_ORD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/gauss_jordan_row_reducer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_row_reducer_test: self-checking bench for the row reducer
// Loads augmented matrices under several sizes, reduces them in a local
// fixed-point predictor and compares every emitted item, with random gaps
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module gauss_jordan_row_reducer_test;
    import grr_pkg::*;

    localparam int N_ROWS      = DEF_MAX_ROWS;
    localparam int N_COLS      = DEF_MAX_COLS;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int IDLE_WAIT   = 300;
    localparam int ITEM_GOAL   = 250;

    class rref_scoreboard;
        logic signed [31:0] coeff[N_ROWS][N_COLS];
        logic [2:0]         unknowns;
        logic [3:0]         eq_rows;
        t_out_item          pending[$];
        int                 errors;

        function new();
            unknowns = 3'd7;
            eq_rows  = 4'd8;
            errors   = 0;
            foreach (coeff[r, c]) coeff[r][c] = '0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic signed [31:0] sat(longint v);
            if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
            if (v < -longint'(32'sh7FFFFFFF) - 1) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] div_fx(logic signed [31:0] a, logic signed [31:0] p);
            longint num;
            num = longint'(a) * (longint'(1) << FRAC);
            return sat(num / longint'(p));
        endfunction

        function logic signed [31:0] mul_sub_fx(logic signed [31:0] a,
                                                logic signed [31:0] b,
                                                logic signed [31:0] f);
            longint prod;
            prod = longint'(b) * longint'(f);
            return sat(longint'(a) - prod / (longint'(1) << FRAC));
        endfunction

        function int rows_in_use();
            return (eq_rows > N_ROWS) ? N_ROWS : int'(eq_rows);
        endfunction

        function int row_width();
            return (int'(unknowns) + 1 > N_COLS) ? N_COLS : int'(unknowns) + 1;
        endfunction

        function void reduce_rows(int rows, int width);
            bit [N_ROWS-1:0]    used;
            logic signed [31:0] piv;
            logic signed [31:0] f;
            used = '0;
            for (int x = 0; x + 1 < width; x++) begin
                for (int y = 0; y < rows; y++) begin
                    if (used[y]) continue;
                    piv = coeff[y][x];
                    if (piv == 0) continue;
                    for (int c = 0; c < width; c++) coeff[y][c] = div_fx(coeff[y][c], piv);
                    used[y] = 1'b1;
                    for (int r = 0; r < rows; r++) begin
                        if (r == y) continue;
                        f = coeff[r][x];
                        if (f == 0) continue;
                        for (int c = 0; c < width; c++)
                            coeff[r][c] = mul_sub_fx(coeff[r][c], coeff[y][c], f);
                    end
                end
            end
        endfunction

        function void note_config(logic idx, logic [3:0] data);
            if (idx == CFG_VAR_COUNT) unknowns = data[2:0];
            else eq_rows = data;
        endfunction

        function void note_input(t_in_item it);
            t_out_item exp_item;
            int        rows;
            int        width;
            coeff[it.row_index][it.col_index] = it.elem_value;
            if (!it.last_elem) return;
            rows  = rows_in_use();
            width = row_width();
            reduce_rows(rows, width);
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < width; c++) begin
                    exp_item.out_row   = r[2:0];
                    exp_item.out_col   = c[2:0];
                    exp_item.out_value = coeff[r][c];
                    exp_item.out_last  = (r + 1 == rows && c + 1 == width);
                    pending.push_back(exp_item);
                end
            end
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item row %0d col %0d", got.out_row, got.out_col));
                return;
            end
            want = pending.pop_front();
            if (got.out_row !== want.out_row)
                report($sformatf("row got %0d want %0d", got.out_row, want.out_row));
            if (got.out_col !== want.out_col)
                report($sformatf("col got %0d want %0d", got.out_col, want.out_col));
            if (got.out_value !== want.out_value)
                report($sformatf("value r%0d c%0d got %h want %h", want.out_row,
                                 want.out_col, got.out_value, want.out_value));
            if (got.out_last !== want.out_last)
                report($sformatf("last r%0d c%0d got %b want %b", want.out_row,
                                 want.out_col, got.out_last, want.out_last));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_VAR_COUNT;
    logic [3:0] i_cfg_data = '0;

    rref_scoreboard    sb = new();
    bit [N_ROWS*N_COLS-1:0] loaded = '0;
    int                items_sent = 0;
    int                cycles = 0;
    bit                calm = 1'b0;

    gauss_jordan_row_reducer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("gauss_jordan_row_reducer_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    function int draw_wait();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task send_elem(int r, int c, logic signed [31:0] v, bit last);
        int n;
        n = draw_wait();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_in_item.row_index  <= r[2:0];
        i_in_item.col_index  <= c[2:0];
        i_in_item.elem_value <= v;
        i_in_item.last_elem  <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(i_in_item);
        loaded[r*N_COLS+c] = 1'b1;
        items_sent++;
    endtask

    task settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task write_reg(logic idx, logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.note_config(idx, data);
    endtask

    task set_size(logic [3:0] unknowns, logic [3:0] eqs);
        settle();
        write_reg(CFG_VAR_COUNT, unknowns);
        write_reg(CFG_ROW_COUNT, eqs);
        @(posedge i_clk);
    endtask

    function logic signed [31:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3, 4: return $signed($urandom_range(0, 16) - 8) * (32'sd1 << FRAC);
            5, 6:    return $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
            7:       return $urandom;
            8:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
        endcase
    endfunction

    // load one matrix of the current size in shuffled order, then trigger
    task solve_matrix();
        int order[N_ROWS*N_COLS];
        int rows;
        int width;
        int j;
        int tmp;
        int r;
        int c;
        int pick;
        rows  = sb.rows_in_use();
        width = sb.row_width();
        foreach (order[i]) order[i] = i;
        for (int i = N_ROWS*N_COLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        pick = (rows == 0) ? $urandom_range(0, N_ROWS*N_COLS - 1)
                           : $urandom_range(0, rows - 1) * N_COLS + $urandom_range(0, width - 1);
        foreach (order[i]) begin
            r = order[i] / N_COLS;
            c = order[i] % N_COLS;
            if (order[i] == pick) continue;
            if (r < rows && c < width) begin
                if (!loaded[order[i]] || $urandom_range(0, 3) != 0)
                    send_elem(r, c, draw_value(), 1'b0);
            end else if ($urandom_range(0, 15) == 0) begin
                send_elem(r, c, draw_value(), 1'b0);
            end
        end
        send_elem(pick / N_COLS, pick % N_COLS, draw_value(), 1'b1);
    endtask

    initial begin
        logic [3:0] unk;
        logic [3:0] eqs;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(4'd0, 4'd1);
        send_elem(0, 0, 32'sh7FFFFFFF, 1'b1);
        send_elem(0, 0, 32'sh80000000, 1'b1);

        set_size(4'd1, 4'd2);
        send_elem(0, 0, 32'sd0, 1'b0);
        send_elem(0, 1, 32'sd5 <<< FRAC, 1'b0);
        send_elem(1, 0, 32'sd2 <<< FRAC, 1'b0);
        send_elem(1, 1, 32'sh7FFFFFFF, 1'b1);
        send_elem(0, 0, 32'sd1, 1'b0);
        send_elem(1, 0, 32'sh80000000, 1'b0);
        send_elem(0, 1, 32'sh7FFFFFFF, 1'b0);
        send_elem(1, 1, 32'sh80000000, 1'b1);
        send_elem(0, 0, 32'sd0, 1'b0);
        send_elem(1, 0, 32'sd0, 1'b0);
        send_elem(0, 1, -32'sd1, 1'b0);
        send_elem(1, 1, 32'sd1, 1'b1);
        send_elem(1, 1, -32'sd3 <<< FRAC, 1'b1);

        set_size(4'd1, 4'd0);
        send_elem(0, 0, 32'sd3 <<< FRAC, 1'b1);

        set_size(4'd7, 4'd15);
        solve_matrix();
        set_size(4'd7, 4'd8);
        solve_matrix();

        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 7))
                0: begin unk = 4'd0; eqs = 4'($urandom_range(0, 15)); end
                1: begin unk = 4'd7; eqs = 4'($urandom_range(1, 8)); end
                2: begin unk = 4'($urandom_range(0, 7)); eqs = 4'($urandom_range(9, 15)); end
                default: begin unk = 4'($urandom_range(1, 3)); eqs = 4'($urandom_range(1, 4)); end
            endcase
            set_size(unk, eqs);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                if (items_sent < ITEM_GOAL) solve_matrix();
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("gauss_jordan_row_reducer_test OK");
        end else begin
            $display("gauss_jordan_row_reducer_test NOT OK");
        end
        $finish;
    end

endmodule
